// ----- sv/mse_pkg.sv -----
// ----------------------------------------------------------------------------
// mse_pkg
// Shared widths, types and state encoding for the mean squared error core.
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int unsigned MAX_LENGTH = 65536;

	localparam int unsigned IN_W      = 16;   // Q8.8 operands
	localparam int unsigned DIFF_W    = IN_W + 1;
	localparam int unsigned SQ_W      = 2 * IN_W;
	localparam int unsigned SUM_W     = 50;   // Q34.16 running sum
	localparam int unsigned CNT_W     = $clog2(MAX_LENGTH + 1);
	localparam int unsigned MEAN_W    = 32;
	localparam int unsigned OUT_CNT_W = 17;
	localparam int unsigned STEP_W    = $clog2(SUM_W + 1);

	localparam int unsigned QDEPTH    = 2;
	localparam int unsigned QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [SUM_W:0]    sum_ext_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [CNT_W:0]    trial_t;
	typedef logic [SQ_W-1:0]   sq_t;
	typedef logic [MEAN_W-1:0] mean_t;
	typedef logic [STEP_W-1:0] step_t;

	localparam sum_t SUM_MAX = '1;
	localparam cnt_t CNT_LIMIT = cnt_t'(MAX_LENGTH);

	// One finished vector, handed from the accumulator to the divider.
	typedef struct packed {
		sum_t sum;
		cnt_t count;
		logic ovf;
	} mse_item_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_HOLD
	} div_state_t;

endpackage

// ----- sv/mean_squared_error_core.sv -----
// ----------------------------------------------------------------------------
// mean_squared_error_core
// Mean of squared Q8.8 differences over a vector, emitted as unsigned Q16.16.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid/in_ready   | pred_value, target_value, last_element
//  out     | out_valid/out_ready | mean_error, element_count, overflow_flag
//
//  Elements accumulate at one per cycle (square register, then 50-bit add).
//  Each vector's mean is computed in the bit-serial divider.
//  A two-entry queue holds finished totals; input stalls only on a last
//  element when that queue is full.
//  Reset (arst_n low) clears sum, count, queue, divider and output valid.
// ----------------------------------------------------------------------------
module mean_squared_error_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [15:0]             pred_value,
	input  logic signed [15:0]             target_value,
	input  logic                           last_element,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mse_pkg::MEAN_W-1:0]     mean_error,
	output logic [mse_pkg::OUT_CNT_W-1:0]  element_count,
	output logic                           overflow_flag
);

	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	mse_pkg::mse_item_t q_wdata;
	mse_pkg::mse_item_t q_rdata;

	mse_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pred_value   (pred_value),
		.target_value (target_value),
		.last_element (last_element),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	mse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	mse_div u_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_data        (q_rdata),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.mean_error    (mean_error),
		.element_count (element_count),
		.overflow_flag (overflow_flag)
	);

endmodule

// ----- sv/mse_front.sv -----
// ----------------------------------------------------------------------------
// mse_front
// Squares each pair's difference and accumulates sum and count; pushes the
// totals of a vector into the queue on its last element.
// ----------------------------------------------------------------------------
module mse_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [15:0]          pred_value,
	input  logic signed [15:0]          target_value,
	input  logic                        last_element,
	input  logic                        q_full,
	output logic                        q_push,
	output mse_pkg::mse_item_t          q_data
);

	logic signed [mse_pkg::DIFF_W-1:0] diff;
	logic [mse_pkg::DIFF_W-1:0]        mag;
	logic                              valid_s1;
	logic                              last_s1;
	mse_pkg::sq_t                      sq_s1;
	logic                              adv_s1;

	mse_pkg::sum_t     sum_q;
	mse_pkg::cnt_t     cnt_q;
	logic              ovf_q;
	mse_pkg::sum_ext_t sum_add;
	mse_pkg::sum_t     sum_nxt;
	mse_pkg::cnt_t     cnt_nxt;
	logic              ovf_nxt;

	assign diff = mse_pkg::DIFF_W'(pred_value) - mse_pkg::DIFF_W'(target_value);
	assign mag  = diff[mse_pkg::DIFF_W-1] ? mse_pkg::DIFF_W'(-diff) : mse_pkg::DIFF_W'(diff);

	// a last element may only leave stage 1 when the queue has room
	assign adv_s1   = valid_s1 && (!last_s1 || !q_full);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			last_s1 <= last_element;
			sq_s1   <= mag[mse_pkg::IN_W-1:0] * mag[mse_pkg::IN_W-1:0];
		end
	end

	assign sum_add = mse_pkg::sum_ext_t'(sum_q) + mse_pkg::sum_ext_t'(sq_s1);

	always_comb begin
		sum_nxt = sum_q;
		cnt_nxt = cnt_q;
		ovf_nxt = ovf_q;
		if (cnt_q >= mse_pkg::CNT_LIMIT) begin
			ovf_nxt = 1'b1;
		end else begin
			sum_nxt = sum_add[mse_pkg::SUM_W] ? mse_pkg::SUM_MAX : sum_add[mse_pkg::SUM_W-1:0];
			cnt_nxt = cnt_q + mse_pkg::cnt_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				sum_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				sum_q <= sum_nxt;
				cnt_q <= cnt_nxt;
				ovf_q <= ovf_nxt;
			end
		end
	end

	assign q_push       = adv_s1 && last_s1;
	assign q_data.sum   = sum_nxt;
	assign q_data.count = cnt_nxt;
	assign q_data.ovf   = ovf_nxt;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mse_pkg::CNT_LIMIT)
		else $error("element count beyond limit");

endmodule

// ----- sv/mse_queue.sv -----
// ----------------------------------------------------------------------------
// mse_queue
// Short FIFO of finished vector totals between accumulator and divider.
// ----------------------------------------------------------------------------
module mse_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mse_pkg::mse_item_t push_data,
	output logic               full,
	input  logic               pop,
	output mse_pkg::mse_item_t pop_data,
	output logic               empty
);

	mse_pkg::mse_item_t               slot_q [mse_pkg::QDEPTH];
	logic [mse_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [mse_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [mse_pkg::QCNT_W-1:0]       fill_q;
	logic                             do_push;
	logic                             do_pop;

	function automatic logic [mse_pkg::QPTR_W-1:0] ptr_inc(input logic [mse_pkg::QPTR_W-1:0] p);
		ptr_inc = (p == mse_pkg::QPTR_W'(mse_pkg::QDEPTH - 1)) ? '0 : p + mse_pkg::QPTR_W'(1);
	endfunction

	assign full     = (fill_q == mse_pkg::QCNT_W'(mse_pkg::QDEPTH));
	assign empty    = (fill_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + mse_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - mse_pkg::QCNT_W'(1);
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= mse_pkg::QCNT_W'(mse_pkg::QDEPTH))
		else $error("queue fill count out of range");

endmodule

// ----- sv/mse_div.sv -----
// ----------------------------------------------------------------------------
// mse_div
// Restoring divider, one quotient bit per cycle: sum / count, low 32 bits of
// the quotient kept. Holds the result in an output register.
// ----------------------------------------------------------------------------
module mse_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  mse_pkg::mse_item_t             q_data,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mse_pkg::MEAN_W-1:0]     mean_error,
	output logic [mse_pkg::OUT_CNT_W-1:0]  element_count,
	output logic                           overflow_flag
);

	mse_pkg::div_state_t state_q, state_nxt;
	mse_pkg::step_t      step_q;
	mse_pkg::sum_t       dvd_q;
	mse_pkg::cnt_t       dvs_q;
	mse_pkg::cnt_t       rem_q;
	mse_pkg::mean_t      quo_q;
	logic                ovf_q;
	logic                out_valid_q;
	logic                out_free;
	logic                step_en;
	logic                load_out;
	mse_pkg::trial_t     trial;
	mse_pkg::trial_t     trial_sub;
	logic                ge;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		q_pop     = 1'b0;
		step_en   = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			mse_pkg::DIV_IDLE: begin
				if (!q_empty) begin
					q_pop     = 1'b1;
					state_nxt = mse_pkg::DIV_RUN;
				end
			end
			mse_pkg::DIV_RUN: begin
				step_en = 1'b1;
				if (step_q == mse_pkg::step_t'(1)) begin
					state_nxt = mse_pkg::DIV_HOLD;
				end
			end
			mse_pkg::DIV_HOLD: begin
				if (out_free) begin
					load_out  = 1'b1;
					state_nxt = mse_pkg::DIV_IDLE;
				end
			end
			default: state_nxt = mse_pkg::DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mse_pkg::DIV_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (q_pop) begin
				step_q <= mse_pkg::step_t'(mse_pkg::SUM_W);
			end else if (step_en) begin
				step_q <= step_q - mse_pkg::step_t'(1);
			end
		end
	end

	assign trial     = {rem_q, dvd_q[mse_pkg::SUM_W-1]};
	assign trial_sub = trial - mse_pkg::trial_t'(dvs_q);
	assign ge        = (trial >= mse_pkg::trial_t'(dvs_q));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dvd_q <= q_data.sum;
			dvs_q <= q_data.count;
			ovf_q <= q_data.ovf;
			rem_q <= '0;
			quo_q <= '0;
		end else if (step_en) begin
			dvd_q <= dvd_q << 1;
			rem_q <= ge ? trial_sub[mse_pkg::CNT_W-1:0] : trial[mse_pkg::CNT_W-1:0];
			quo_q <= {quo_q[mse_pkg::MEAN_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mean_error    <= quo_q;
			element_count <= mse_pkg::OUT_CNT_W'(dvs_q);
			overflow_flag <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mse_pkg::DIV_RUN) |-> (rem_q < dvs_q))
		else $error("partial remainder not below divisor");

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mse_pkg::DIV_RUN) |-> (step_q == '0))
		else $error("step counter live outside run");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mse_pkg::DIV_RUN) |-> (dvs_q != '0))
		else $error("zero divisor");

endmodule

// ----- tb/mean_squared_error_core_tb.sv -----
// ----------------------------------------------------------------------------
// mean_squared_error_core_tb
// Streams Q8.8 prediction/target pairs into the core with random idle and
// stall bursts on both channels. A local model predicts each vector's mean,
// count and overflow flag. Every output transfer is compared field by field.
// ----------------------------------------------------------------------------
module mean_squared_error_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned SUM_CEIL    = (64'd1 << mse_pkg::SUM_W) - 64'd1;
	localparam int              SETTLE      = 80;
	localparam longint          CYCLE_LIMIT = 8000000;

	typedef struct {
		logic signed [15:0] pred;
		logic signed [15:0] target;
		logic               last;
	} pair_t;

	typedef struct {
		logic [mse_pkg::MEAN_W-1:0]    mean;
		logic [mse_pkg::OUT_CNT_W-1:0] count;
		logic                          ovf;
	} mean_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic signed [15:0]                pred_value = '0;
	logic signed [15:0]                target_value = '0;
	logic                              last_element = 1'b0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [mse_pkg::MEAN_W-1:0]        mean_error;
	logic [mse_pkg::OUT_CNT_W-1:0]     element_count;
	logic                              overflow_flag;

	pair_t        pending_pairs[$];
	mean_result_t expected_means[$];

	// running state of the local model
	mse_pkg::sum_t run_sum = '0;
	mse_pkg::cnt_t run_count = '0;
	logic          run_dropped = 1'b0;

	int     mismatches = 0;
	int     in_idle_pct = 0;
	int     out_stall_pct = 0;
	int     in_gap_left = 0;
	int     out_stall_left = 0;
	longint cycle_count = 0;

	mean_squared_error_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pred_value   (pred_value),
		.target_value (target_value),
		.last_element (last_element),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mean_error   (mean_error),
		.element_count(element_count),
		.overflow_flag(overflow_flag)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic report(input string what, input longint unsigned want,
			input longint unsigned got);
		mismatches++;
		$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
	endtask

	// fold one pair into the running sum; close out the vector on last
	task automatic accumulate_pair(input logic signed [15:0] p, input logic signed [15:0] t,
			input logic last);
		int              diff;
		longint unsigned mag;
		longint unsigned sq;
		logic [63:0]     total;
		logic [63:0]     quot;
		mean_result_t    res;
		diff = int'(p) - int'(t);
		mag = (diff < 0) ? longint'(-diff) : longint'(diff);
		sq = mag * mag;
		if (run_count >= mse_pkg::MAX_LENGTH) begin
			run_dropped = 1'b1;
		end else begin
			total = 64'(run_sum) + sq;
			run_sum = (total > SUM_CEIL) ? '1 : total[mse_pkg::SUM_W-1:0];
			run_count++;
		end
		if (last) begin
			quot = 64'(run_sum) / 64'(run_count);
			res.mean = quot[mse_pkg::MEAN_W-1:0];
			res.count = run_count[mse_pkg::OUT_CNT_W-1:0];
			res.ovf = run_dropped;
			expected_means.push_back(res);
			run_sum = '0;
			run_count = '0;
			run_dropped = 1'b0;
		end
	endtask

	// driver: model runs on each accepted transfer
	always @(posedge clk or negedge arst_n) begin
		pair_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap_left = 0;
		end else begin
			if (in_valid && in_ready)
				accumulate_pair(pred_value, target_value, last_element);
			if (!in_valid || in_ready) begin
				if (in_gap_left > 0) begin
					in_gap_left--;
					in_valid <= 1'b0;
				end else if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
					in_gap_left = $urandom_range(1, 10) - 1;
					in_valid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					nxt = pending_pairs.pop_front();
					in_valid <= 1'b1;
					pred_value <= nxt.pred;
					target_value <= nxt.target;
					last_element <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each output transfer, then pick the next ready level
	always @(posedge clk or negedge arst_n) begin
		mean_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_means.size() == 0) begin
					report("unexpected result, mean", 64'd0, 64'(mean_error));
				end else begin
					want = expected_means.pop_front();
					if (mean_error !== want.mean)
						report("mean_error", 64'(want.mean), 64'(mean_error));
					if (element_count !== want.count)
						report("element_count", 64'(want.count), 64'(element_count));
					if (overflow_flag !== want.ovf)
						report("overflow_flag", 64'(want.ovf), 64'(overflow_flag));
				end
			end
			if (out_stall_left > 0) begin
				out_stall_left--;
				out_ready <= 1'b0;
			end else if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct) begin
				out_stall_left = $urandom_range(1, 10) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic push_pair(input logic signed [15:0] p, input logic signed [15:0] t,
			input logic last);
		pair_t it;
		it.pred = p;
		it.target = t;
		it.last = last;
		pending_pairs.push_back(it);
	endtask

	function automatic logic signed [15:0] pick_q88();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_random_vectors(input int budget);
		int added;
		int len;
		int r;
		logic signed [15:0] p;
		logic signed [15:0] t;
		added = 0;
		while (added < budget) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				len = $urandom_range(1, 8);
			else if (r < 92)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(41, 200);
			for (int k = 0; k < len; k++) begin
				p = pick_q88();
				// near misses keep small means in the mix
				if ($urandom_range(0, 3) == 0)
					t = p + 16'($urandom_range(0, 600)) - 16'sd300;
				else
					t = pick_q88();
				push_pair(p, t, k == len - 1);
			end
			added += len;
		end
	endtask

	// hold off until everything sent has come back
	task automatic drain();
		while (pending_pairs.size() != 0 || in_valid || expected_means.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, truncation, sign patterns
		in_idle_pct = 20;
		out_stall_pct = 20;
		push_pair(16'sh7FFF, 16'sh8000, 1'b1);
		push_pair(16'sh8000, 16'sh7FFF, 1'b1);
		push_pair(16'sh0000, 16'sh0000, 1'b1);
		push_pair(16'sh8000, 16'sh8000, 1'b1);
		push_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
		push_pair(16'sh0001, 16'sh0000, 1'b0);
		push_pair(16'sh0000, 16'sh0001, 1'b0);
		push_pair(16'sh0000, 16'sh0000, 1'b1);
		push_pair(16'sh0100, 16'sh0000, 1'b0);
		push_pair(16'sh0000, -16'sh0100, 1'b1);
		push_pair(16'sh5555, 16'shAAAA, 1'b1);
		push_pair(16'shAAAA, 16'sh5555, 1'b1);
		push_pair(-16'sd1, 16'sd1, 1'b0);
		push_pair(16'sd7, -16'sd3, 1'b0);
		push_pair(-16'sd300, 16'sd200, 1'b1);
		push_pair(16'sh8000, 16'sh0000, 1'b0);
		push_pair(16'sh0000, 16'sh7FFF, 1'b1);
		drain();

		in_idle_pct = 15;
		out_stall_pct = 25;
		queue_random_vectors(450);
		// fast source against a slow sink fills the result queue
		in_idle_pct = 0;
		out_stall_pct = 60;
		queue_random_vectors(140);
		drain();

		in_idle_pct = 25;
		out_stall_pct = 10;
		queue_random_vectors(300);
		drain();

		// closing stretch runs flat out
		in_idle_pct = 0;
		out_stall_pct = 0;
		queue_random_vectors(250);
		drain();
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0 && expected_means.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
